// ----- rtl/core/msca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_pkg: shared types and constants of the scanned, calibrated averager
// Sizes of the channel scan, the history and the item fields, the queued
// work record and the request kinds.
// ----------------------------------------------------------------------------
package msca_pkg;

   // scan and history geometry (AVG_DEPTH is a power of two)
   localparam int NUM_CHANNELS = 16;
   localparam int AVG_DEPTH    = 4;
   localparam int SAMPLE_BITS  = 12;
   localparam int QUEUE_DEPTH  = 2;

   localparam int CHAN_W      = 4;
   localparam int CHAN_IDX_W  = $clog2(NUM_CHANNELS);
   localparam int SLOT_BITS   = $clog2(AVG_DEPTH);
   localparam int HIST_DEPTH  = NUM_CHANNELS * AVG_DEPTH;
   localparam int HIST_AW     = $clog2(HIST_DEPTH);
   localparam int SUM_W       = SAMPLE_BITS + SLOT_BITS;
   localparam int DIV_CNT_W   = $clog2(SAMPLE_BITS + 1);

   // beat layouts
   localparam int REQ_FIELDS_W = 3 * SAMPLE_BITS + CHAN_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * CHAN_W + SAMPLE_BITS;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CHAN_W-1:0]      chan_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;

   localparam sample_type FULL_CODE = '1;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_CAL    = 1'b1
   } req_kind_type;

   // one sample resolved by the front end, ready for mapping and averaging
   typedef struct packed {
      chan_type   channel;
      slot_type   slot;
      sample_type raw;
      sample_type lo;
      sample_type hi;
      chan_type   next_sel;
   } job_type;

endpackage

// ----- rtl/core/msca_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_front: request decode, scan state and calibration store
// Applies calibration writes at once and turns each sample beat into a
// work record carrying the channel, history slot and calibration pair.
// ----------------------------------------------------------------------------
module msca_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // raw_sample, cal_channel, cal_min, cal_max (from bit 0 up)
   input  logic [msca_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic                              req_tuser,
   output logic                              push_valid,
   output msca_pkg::job_type                 push_job,
   input  logic                              push_ready
);

   localparam int W = msca_pkg::SAMPLE_BITS;
   localparam int C = msca_pkg::CHAN_W;

   msca_pkg::chan_type   scan_ff, scan_in;
   msca_pkg::slot_type   slot_ff, slot_in;
   msca_pkg::sample_type low_ff  [msca_pkg::NUM_CHANNELS];
   msca_pkg::sample_type high_ff [msca_pkg::NUM_CHANNELS];

   msca_pkg::sample_type raw_sample, cal_min, cal_max;
   msca_pkg::chan_type   cal_channel;
   logic                 accept, is_cal, cal_hit;

   // field unpack
   assign raw_sample  = req_tdata[W-1:0];
   assign cal_channel = req_tdata[W+C-1:W];
   assign cal_min     = req_tdata[2*W+C-1:W+C];
   assign cal_max     = req_tdata[3*W+C-1:2*W+C];

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign is_cal     = (msca_pkg::req_kind_type'(req_tuser) == msca_pkg::REQ_CAL);
   assign cal_hit    = accept && is_cal &&
                       ({1'b0, cal_channel} < (C + 1)'(msca_pkg::NUM_CHANNELS));

   // round-robin pointer; slot steps when the scan wraps
   always_comb begin
      scan_in = scan_ff;
      slot_in = slot_ff;
      if (scan_ff == C'(msca_pkg::NUM_CHANNELS - 1)) begin
         scan_in = '0;
         if (slot_ff == msca_pkg::SLOT_BITS'(msca_pkg::AVG_DEPTH - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end else begin
         scan_in = scan_ff + 1'b1;
      end
   end

   // work record for the back end
   assign push_valid        = accept && !is_cal;
   assign push_job.channel  = scan_ff;
   assign push_job.slot     = slot_ff;
   assign push_job.raw      = raw_sample;
   assign push_job.lo       = low_ff[scan_ff[msca_pkg::CHAN_IDX_W-1:0]];
   assign push_job.hi       = high_ff[scan_ff[msca_pkg::CHAN_IDX_W-1:0]];
   assign push_job.next_sel = scan_in;

   // scan state and calibration pairs
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         slot_ff <= '0;
         for (int i = 0; i < msca_pkg::NUM_CHANNELS; i++) begin
            low_ff[i]  <= '0;
            high_ff[i] <= msca_pkg::FULL_CODE;
         end
      end else begin
         if (push_valid) begin
            scan_ff <= scan_in;
            slot_ff <= slot_in;
         end
         if (cal_hit) begin
            low_ff[cal_channel[msca_pkg::CHAN_IDX_W-1:0]]  <= cal_min;
            high_ff[cal_channel[msca_pkg::CHAN_IDX_W-1:0]] <= cal_max;
         end
      end
   end

   // scan pointer never leaves the channel range
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, scan_ff} < (C + 1)'(msca_pkg::NUM_CHANNELS))
      else $error("scan pointer out of range");

   // history slot only moves on a scan wrap
   a_slot_wrap: assert property (@(posedge clock) disable iff (reset)
      !$stable(slot_ff) |-> (scan_ff == '0))
      else $error("history slot moved without scan wrap");

endmodule

// ----- rtl/core/msca_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_queue: short work queue between front and back end
// Register FIFO of work records; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module msca_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  msca_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output msca_pkg::job_type pop_job,
   input  logic              pop_ready
);

   localparam int QA_W = $clog2(msca_pkg::QUEUE_DEPTH);

   msca_pkg::job_type entry_ff [msca_pkg::QUEUE_DEPTH];
   logic [QA_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QA_W:0]     count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QA_W + 1)'(msca_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QA_W'(msca_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QA_W'(msca_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/core/msca_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_back: calibration mapping, history and averaging
// Maps one sample through its calibration pair, with a bit-serial divider
// where needed, sums the other history slots from the history RAM meanwhile,
// writes the new value back and registers the result beat.
// ----------------------------------------------------------------------------
module msca_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   input  msca_pkg::job_type                 pop_job,
   output logic                              pop_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // channel, level, next_select (from bit 0 up)
   output logic [msca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // bad_cal
   output logic                              rsp_tuser
);

   localparam int W  = msca_pkg::SAMPLE_BITS;
   localparam int SB = msca_pkg::SLOT_BITS;
   localparam int AW = msca_pkg::HIST_AW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_WORK,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_FULL,
      MODE_DIV
   } mode_type;

   state_type                    state_ff, state_in;
   msca_pkg::job_type            job_ff, job_in;
   mode_type                     mode_ff, mode_in;
   logic                         bad_ff, bad_in;
   logic [W-1:0]                 den_ff, den_in;
   logic [W:0]                   rem_ff, rem_in;
   logic [W-1:0]                 dvd_ff, dvd_in;
   logic [W-1:0]                 quo_ff, quo_in;
   logic [msca_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [SB:0]                  rd_idx_ff, rd_idx_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic                         rd_skip_ff, rd_skip_in;
   logic [msca_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic [msca_pkg::HIST_DEPTH-1:0] hist_valid_ff, hist_valid_in;
   logic                         out_valid_ff, out_valid_in;
   msca_pkg::chan_type           out_chan_ff, out_chan_in;
   msca_pkg::sample_type         out_level_ff, out_level_in;
   msca_pkg::chan_type           out_next_ff, out_next_in;
   logic                         out_bad_ff, out_bad_in;

   msca_pkg::sample_type         hist_mem [msca_pkg::HIST_DEPTH];
   msca_pkg::sample_type         rd_data_ff;

   logic                         rd_issue, hist_we, out_load;
   logic [AW-1:0]                rd_addr, wr_addr;
   msca_pkg::sample_type         mapped;

   assign pop_ready = (state_ff == ST_IDLE);
   assign rd_issue  = (state_ff == ST_WORK) && (rd_idx_ff != (SB + 1)'(msca_pkg::AVG_DEPTH));
   assign rd_addr   = AW'({job_ff.channel, rd_idx_ff[SB-1:0]});
   assign wr_addr   = AW'({job_ff.channel, job_ff.slot});

   // mapped value from the mapping class
   always_comb begin
      case (mode_ff)
         MODE_DIV:  mapped = msca_pkg::FULL_CODE - quo_ff;
         MODE_FULL: mapped = msca_pkg::FULL_CODE;
         default:   mapped = '0;
      endcase
   end

   // sequencer, divider, history sum and result stage
   always_comb begin
      logic signed [W:0] delta, span;
      logic [W-1:0]      abs_d, abs_s;
      logic [2*W-1:0]    num;
      logic [W:0]        rem_sh;
      logic [msca_pkg::SUM_W-1:0] sum;

      state_in      = state_ff;
      job_in        = job_ff;
      mode_in       = mode_ff;
      bad_in        = bad_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = rd_issue;
      rd_skip_in    = rd_skip_ff;
      acc_in        = acc_ff;
      hist_valid_in = hist_valid_ff;
      out_chan_in   = out_chan_ff;
      out_level_in  = out_level_ff;
      out_next_in   = out_next_ff;
      out_bad_in    = out_bad_ff;
      hist_we       = 1'b0;
      out_load      = 1'b0;

      delta  = $signed({1'b0, job_ff.raw}) - $signed({1'b0, job_ff.lo});
      span   = $signed({1'b0, job_ff.hi}) - $signed({1'b0, job_ff.lo});
      abs_d  = delta[W] ? W'(-delta) : delta[W-1:0];
      abs_s  = span[W]  ? W'(-span)  : span[W-1:0];
      num    = {abs_d, {W{1'b0}}} - {{W{1'b0}}, abs_d};
      rem_sh = {rem_ff[W-1:0], dvd_ff[W-1]};
      sum    = acc_ff + msca_pkg::SUM_W'(mapped);

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               job_in   = pop_job;
               state_in = ST_PREP;
            end
         end

         // classify: only same-sign, in-range offsets need the divider
         ST_PREP: begin
            bad_in     = (job_ff.hi == job_ff.lo);
            den_in     = abs_s;
            rem_in     = {1'b0, num[2*W-1:W]};
            dvd_in     = num[W-1:0];
            quo_in     = '0;
            div_cnt_in = '0;
            rd_idx_in  = '0;
            acc_in     = '0;
            if (job_ff.hi == job_ff.lo) begin
               mode_in = MODE_ZERO;
            end else if ((delta == '0) || (delta[W] != span[W])) begin
               mode_in = MODE_FULL;
            end else if (abs_d > abs_s) begin
               mode_in = MODE_ZERO;
            end else begin
               mode_in    = MODE_DIV;
               div_cnt_in = msca_pkg::DIV_CNT_W'(W);
            end
            state_in = ST_WORK;
         end

         ST_WORK: begin
            // one restoring quotient bit per cycle
            if (div_cnt_ff != '0) begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_in = rem_sh - {1'b0, den_ff};
                  quo_in = {quo_ff[W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[W-2:0], 1'b0};
               end
               dvd_in     = dvd_ff << 1;
               div_cnt_in = div_cnt_ff - 1'b1;
            end
            // walk the channel's slots; own slot and unwritten ones count 0
            if (rd_issue) begin
               rd_skip_in = (rd_idx_ff[SB-1:0] == job_ff.slot) || !hist_valid_ff[rd_addr];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
            if (rd_pend_ff && !rd_skip_ff) begin
               acc_in = acc_ff + msca_pkg::SUM_W'(rd_data_ff);
            end
            if ((div_cnt_ff == '0) && !rd_issue && !rd_pend_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               hist_we                = 1'b1;
               hist_valid_in[wr_addr] = 1'b1;
               out_load               = 1'b1;
               out_chan_in            = job_ff.channel;
               out_level_in           = sum[msca_pkg::SUM_W-1:SB];
               out_next_in            = job_ff.next_sel;
               out_bad_in             = bad_ff;
               state_in               = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // history RAM, registered read
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
      if (hist_we) begin
         hist_mem[wr_addr] <= mapped;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pend_ff    <= 1'b0;
         hist_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         hist_valid_ff <= hist_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      job_ff       <= job_in;
      mode_ff      <= mode_in;
      bad_ff       <= bad_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      rd_idx_ff    <= rd_idx_in;
      rd_skip_ff   <= rd_skip_in;
      acc_ff       <= acc_in;
      out_chan_ff  <= out_chan_in;
      out_level_ff <= out_level_in;
      out_next_ff  <= out_next_in;
      out_bad_ff   <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = msca_pkg::RSP_DATA_W'({out_next_ff, out_level_ff, out_chan_ff});
   assign rsp_tuser  = out_bad_ff;

   // divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WORK) && (mode_ff == MODE_DIV)) |-> (rem_ff < {1'b0, den_ff}))
      else $error("divider remainder not below divisor");

   // a pending RAM read was issued while working
   a_read_origin: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff == ST_WORK))
      else $error("history read outside work phase");

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten");

endmodule

// ----- rtl/core/mux_scan_calibrated_averager_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mux_scan_calibrated_averager_top: scanned channel averager, top level
// Front end, work queue and mapping/averaging back end.
// ----------------------------------------------------------------------------
// Each sample beat belongs to the channel the internal round-robin pointer
// selects; it is mapped inversely through that channel's calibration pair
// (full scale minus the scaled offset, truncated, clamped to 0..4095, zero
// with bad_cal set when min equals max), written to a four-deep history and
// answered with the floor average and the select for the next sample.
// Calibration beats (req_tuser high) are written to the store when accepted,
// apply to later sample beats and produce no response. Sample beats queue
// two deep; the back end takes one sample at a time and works one that needs
// the divider through pop, classify, a work phase (the 12-bit bit-serial
// divider steps with the history RAM reads alongside and one closing check),
// then write-back and result load, so the divider sets the sustained rate.
// A sample whose mapping is a plain clamp or zero skips the divider steps.
// A waiting result holds the back end in its last cycle until it is taken.
// History starts as all zeros after reset without a clearing pass.
// ----------------------------------------------------------------------------
module mux_scan_calibrated_averager_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // raw_sample, cal_channel, cal_min, cal_max (from bit 0 up)
   input  logic [msca_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // channel, level, next_select (from bit 0 up)
   output logic [msca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // bad_cal
   output logic                              rsp_tuser
);

   logic              push_valid, push_ready, pop_valid, pop_ready;
   msca_pkg::job_type push_job, pop_job;

   msca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   msca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   msca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/msca_level_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msca_level_checker: response checker for the scanned, calibrated averager
// Watches both streams. Each accepted request beat updates a private copy of
// the calibration pairs, scan pointer and history; a sample beat queues the
// response that it must cause. Each accepted response beat is compared, field
// by field, with the oldest queued one.
// ----------------------------------------------------------------------------
module msca_level_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // raw_sample, cal_channel, cal_min, cal_max (from bit 0 up)
   input  logic [msca_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // channel, level, next_select (from bit 0 up)
   input  logic [msca_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bad_cal
   input  logic                            rsp_tuser,
   output int                              error_count,
   output int                              checked_count,
   output int                              bad_cal_count,
   output int                              pending_count
);

   localparam int SB = msca_pkg::SAMPLE_BITS;
   localparam int CW = msca_pkg::CHAN_W;

   typedef struct packed {
      msca_pkg::chan_type   channel;
      msca_pkg::sample_type level;
      msca_pkg::chan_type   next_sel;
      logic                 bad_cal;
   } level_result_type;

   // private copy of the block's state
   msca_pkg::chan_type   scan_ptr;
   msca_pkg::slot_type   hist_slot;
   msca_pkg::sample_type hist_mem [msca_pkg::HIST_DEPTH];
   msca_pkg::sample_type lo_tab   [msca_pkg::NUM_CHANNELS];
   msca_pkg::sample_type hi_tab   [msca_pkg::NUM_CHANNELS];

   level_result_type expected_levels [$];

   // map one raw reading of the current channel, fold it into the history
   // and return the response it must produce; advances the scan
   task automatic average_sample(input msca_pkg::sample_type x,
                                 output level_result_type res);
      longint               delta;
      longint               span;
      longint               mapped;
      int unsigned          level_sum;
      int                   i;
      logic                 unusable;
      msca_pkg::sample_type lo;
      msca_pkg::sample_type hi;
      lo       = lo_tab[scan_ptr];
      hi       = hi_tab[scan_ptr];
      unusable = (lo == hi);
      if (unusable) begin
         mapped = 0;
      end else begin
         delta  = longint'(x) - longint'(lo);
         span   = longint'(hi) - longint'(lo);
         // SV signed division truncates toward zero
         mapped = longint'(msca_pkg::FULL_CODE)
                  + (delta * -longint'(msca_pkg::FULL_CODE)) / span;
         if (mapped < 0)
            mapped = 0;
         if (mapped > longint'(msca_pkg::FULL_CODE))
            mapped = longint'(msca_pkg::FULL_CODE);
      end
      hist_mem[scan_ptr * msca_pkg::AVG_DEPTH + hist_slot] = msca_pkg::sample_type'(mapped);
      level_sum = 0;
      for (i = 0; i < msca_pkg::AVG_DEPTH; i++)
         level_sum += hist_mem[scan_ptr * msca_pkg::AVG_DEPTH + i];
      res.channel = scan_ptr;
      res.level   = msca_pkg::sample_type'(level_sum / msca_pkg::AVG_DEPTH);
      res.bad_cal = unusable;
      // round robin; the history slot moves on once per full sweep
      if (scan_ptr == msca_pkg::CHAN_W'(msca_pkg::NUM_CHANNELS - 1)) begin
         scan_ptr  = '0;
         hist_slot = (hist_slot == msca_pkg::SLOT_BITS'(msca_pkg::AVG_DEPTH - 1)) ?
                     '0 : hist_slot + 1'b1;
      end else begin
         scan_ptr = scan_ptr + 1'b1;
      end
      res.next_sel = scan_ptr;
   endtask

   always @(posedge clock) begin : watch
      level_result_type   want;
      level_result_type   got;
      level_result_type   fresh;
      msca_pkg::chan_type cal_ch;
      int                 errs;
      int                 i;
      errs = 0;
      if (reset) begin
         scan_ptr  = '0;
         hist_slot = '0;
         for (i = 0; i < msca_pkg::HIST_DEPTH; i++)
            hist_mem[i] = '0;
         for (i = 0; i < msca_pkg::NUM_CHANNELS; i++) begin
            lo_tab[i] = '0;
            hi_tab[i] = msca_pkg::FULL_CODE;
         end
         expected_levels.delete();
         error_count   <= 0;
         checked_count <= 0;
         bad_cal_count <= 0;
         pending_count <= 0;
      end else begin
         // response side first: it can only answer an earlier request
         if (rsp_tvalid && rsp_tready) begin
            got.channel  = rsp_tdata[CW-1:0];
            got.level    = rsp_tdata[CW+SB-1:CW];
            got.next_sel = rsp_tdata[2*CW+SB-1:CW+SB];
            got.bad_cal  = rsp_tuser;
            if (expected_levels.size() == 0) begin
               $display("%0t: response beat with nothing expected (channel %0d level %0d)",
                        $time, got.channel, got.level);
               errs++;
            end else begin
               want = expected_levels.pop_front();
               if (got.channel !== want.channel) begin
                  $display("%0t: channel expected %0d actual %0d",
                           $time, want.channel, got.channel);
                  errs++;
               end
               if (got.level !== want.level) begin
                  $display("%0t: level (channel %0d) expected %0d actual %0d",
                           $time, want.channel, want.level, got.level);
                  errs++;
               end
               if (got.next_sel !== want.next_sel) begin
                  $display("%0t: next_select (channel %0d) expected %0d actual %0d",
                           $time, want.channel, want.next_sel, got.next_sel);
                  errs++;
               end
               if (got.bad_cal !== want.bad_cal) begin
                  $display("%0t: bad_cal (channel %0d) expected %0b actual %0b",
                           $time, want.channel, want.bad_cal, got.bad_cal);
                  errs++;
               end
               checked_count <= checked_count + 1;
               if (want.bad_cal)
                  bad_cal_count <= bad_cal_count + 1;
            end
         end
         // request side
         if (req_tvalid && req_tready) begin
            if (req_tuser == msca_pkg::REQ_CAL) begin
               cal_ch = req_tdata[SB+CW-1:SB];
               if (cal_ch < msca_pkg::NUM_CHANNELS) begin
                  lo_tab[cal_ch] = req_tdata[2*SB+CW-1:SB+CW];
                  hi_tab[cal_ch] = req_tdata[3*SB+CW-1:2*SB+CW];
               end
            end else begin
               average_sample(req_tdata[SB-1:0], fresh);
               expected_levels.insert(expected_levels.size(), fresh);
            end
         end
         error_count   <= error_count + errs;
         pending_count <= expected_levels.size();
      end
   end

endmodule

// ----- tb/tb_mux_scan_calibrated_averager_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mux_scan_calibrated_averager_top: testbench for the scanned averager
// Drives a directed opening (scale extremes, equal, reversed and one-code
// calibration pairs) and then random calibration and sample beats under four
// idle/stall mixes, with one long output hold-off. A checker beside the block
// predicts and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_mux_scan_calibrated_averager_top;

   localparam int REQ_W       = msca_pkg::REQ_DATA_W;
   localparam int RSP_W       = msca_pkg::RSP_DATA_W;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 64;
   localparam int HOLD_CYCLES = 400;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             hold_rsp   = 1'b0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int          beats_sent    = 0;
   int          samples_sent  = 0;
   int          cals_sent     = 0;
   int          error_count;
   int          checked_count;
   int          bad_cal_count;
   int          pending_count;

   // stimulus-side view of the scan and calibration, used only to aim samples
   msca_pkg::chan_type   scan_idx = '0;
   msca_pkg::sample_type cal_lo_sh [msca_pkg::NUM_CHANNELS];
   msca_pkg::sample_type cal_hi_sh [msca_pkg::NUM_CHANNELS];

   always #10 clock = ~clock;

   mux_scan_calibrated_averager_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   msca_level_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .checked_count (checked_count),
      .bad_cal_count (bad_cal_count),
      .pending_count (pending_count)
   );

   // output side: random stalls, forced low during a hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // long output hold-off while the sender keeps offering beats
   initial begin
      wait (beats_sent >= 200);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("mux_scan_calibrated_averager_top verification failed");
      $finish;
   end

   function automatic msca_pkg::sample_type clip_code(input int v);
      if (v < 0)
         return '0;
      if (v > int'(msca_pkg::FULL_CODE))
         return msca_pkg::FULL_CODE;
      return msca_pkg::sample_type'(v);
   endfunction

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(input msca_pkg::req_kind_type kind,
                            input msca_pkg::sample_type raw,
                            input msca_pkg::chan_type ch,
                            input msca_pkg::sample_type lo,
                            input msca_pkg::sample_type hi);
      logic [REQ_W-1:0] word;
      word = '0;
      word[msca_pkg::REQ_FIELDS_W-1:0] = {hi, lo, ch, raw};
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      beats_sent++;
   endtask

   // calibration beat; the raw field carries junk
   task automatic send_cal(input msca_pkg::chan_type ch,
                           input msca_pkg::sample_type lo,
                           input msca_pkg::sample_type hi);
      send_beat(msca_pkg::REQ_CAL, msca_pkg::sample_type'($urandom), ch, lo, hi);
      cal_lo_sh[ch] = lo;
      cal_hi_sh[ch] = hi;
      cals_sent++;
   endtask

   // sample beat for the current channel; calibration fields carry junk
   task automatic send_sample(input msca_pkg::sample_type x);
      send_beat(msca_pkg::REQ_SAMPLE, x, msca_pkg::chan_type'($urandom),
                msca_pkg::sample_type'($urandom), msca_pkg::sample_type'($urandom));
      scan_idx = scan_idx + 1'b1;
      samples_sent++;
   endtask

   // random beat: mostly samples aimed around the live calibration
   task automatic random_beat();
      int unsigned          style;
      msca_pkg::chan_type   ch;
      msca_pkg::sample_type lo;
      msca_pkg::sample_type hi;
      msca_pkg::sample_type x;
      style = $urandom_range(9);
      if ($urandom_range(99) < 18) begin
         ch = msca_pkg::chan_type'($urandom_range(msca_pkg::NUM_CHANNELS - 1));
         lo = msca_pkg::sample_type'($urandom);
         hi = msca_pkg::sample_type'($urandom);
         case (style)
            4: hi = lo;
            5: begin
               lo = '0;
               hi = msca_pkg::FULL_CODE;
            end
            6: hi = clip_code(int'(lo) + int'($urandom_range(1, 95)));
            7: lo = clip_code(int'(hi) + int'($urandom_range(1, 95)));
            8: begin
               lo = msca_pkg::FULL_CODE;
               hi = '0;
            end
            default: ;
         endcase
         send_cal(ch, lo, hi);
      end else begin
         lo = cal_lo_sh[scan_idx];
         hi = cal_hi_sh[scan_idx];
         x  = msca_pkg::sample_type'($urandom);
         case (style)
            5: x = lo;
            6: x = hi;
            7: x = clip_code(int'(lo) + int'($urandom_range(6)) - 3);
            8: x = clip_code(int'(hi) + int'($urandom_range(6)) - 3);
            9: x = $urandom_range(1) ? msca_pkg::FULL_CODE : '0;
            default: ;
         endcase
         send_sample(x);
      end
   endtask

   task automatic run_phase(input int n, input int unsigned idle_pct,
                            input int unsigned stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      repeat (n)
         random_beat();
   endtask

   initial begin
      int  guard;
      int  i;
      logic failed;
      for (i = 0; i < msca_pkg::NUM_CHANNELS; i++) begin
         cal_lo_sh[i] = '0;
         cal_hi_sh[i] = msca_pkg::FULL_CODE;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening: odd calibration pairs, then one full sweep
      send_cal(4'd2, 12'd2048, 12'd2048);           // equal pair, mid scale
      send_cal(4'd3, msca_pkg::FULL_CODE, 12'd0);   // fully reversed
      send_cal(4'd4, 12'd0, 12'd1);                 // one-code span
      send_cal(4'd15, 12'd100, 12'd200);
      send_cal(4'd5, msca_pkg::FULL_CODE, msca_pkg::FULL_CODE);
      send_sample(12'd0);
      send_sample(msca_pkg::FULL_CODE);
      send_sample(12'd2048);
      send_sample(12'd0);
      send_sample(12'd1);
      send_sample(msca_pkg::FULL_CODE);
      send_sample(12'd2047);
      send_sample(12'd1);
      send_sample(12'd4094);
      repeat (6)
         send_sample(msca_pkg::sample_type'($urandom));
      send_sample(12'd150);
      send_cal(4'd0, 12'd0, 12'd0);                 // equal pair at zero
      send_cal(4'd2, 12'd0, msca_pkg::FULL_CODE);
      send_cal(4'd5, 12'd1000, 12'd3000);
      send_sample(msca_pkg::FULL_CODE);             // channel 0, second slot

      // random part under the four idle/stall mixes
      run_phase(225, 0, 0);
      run_phase(225, 46, 0);
      run_phase(225, 0, 46);
      run_phase(225, 25, 25);
      req_tvalid <= 1'b0;

      // drain
      @(posedge clock);
      guard = 0;
      while (pending_count != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      failed = (error_count != 0) || (pending_count != 0);
      if (pending_count != 0)
         $display("%0t: %0d expected responses never arrived", $time, pending_count);
      $display("Covered %0d sample and %0d calibration beats; %0d responses checked, %0d of them",
               samples_sent, cals_sent, checked_count, bad_cal_count);
      $display("with an unusable pair, over four idle/stall mixes and one long output hold-off.");
      if (!failed)
         $display("mux_scan_calibrated_averager_top verification clean");
      else
         $display("mux_scan_calibrated_averager_top verification failed");
      $finish;
   end

endmodule
